// File: rtl/lsob_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsob_pkg
// Shared types, constants and helpers for the leg swing offset blender.
// ----------------------------------------------------------------------------
package lsob_pkg;

    localparam int POS_W   = 24;
    localparam int PHASE_W = 18;
    localparam int LEG_W   = 2;
    localparam int T_W     = 17;   // clamped phase 0..65536
    localparam int K_W     = 18;   // 3 - 2t in Q16, 65536..196608
    localparam int DIFF_W  = POS_W + 1;
    localparam int PROD_W  = DIFF_W + T_W + 1;

    localparam int LEGS_DEF = 4;
    localparam int LEGS_MAX = 8;

    localparam logic [T_W-1:0] Q16_ONE   = 17'd65536;
    localparam logic [K_W-1:0] Q16_THREE = 18'd196608;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

    // controller sequence, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SQ    = 6'b000010,
        ST_WT    = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_OFF   = 6'b010000,
        ST_DONE  = 6'b100000
    } lsob_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture transaction and per-leg state
        logic sq_en;     // t*t and 3-2t
        logic wt_en;     // smoothstep weight
        logic mul_en;    // difference times weight
        logic off_en;    // blended offset, current offset update
        logic out_load;  // result register load
    } lsob_cmd_t;

    // saturate a 25-bit sum to 24 bits
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
        logic signed [POS_W-1:0] r;
        if (v[POS_W] != v[POS_W-1]) begin
            r = v[POS_W] ? POS_MIN : POS_MAX;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/lsob_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsob_ctrl
// Sequencer: steps the datapath through one transaction and owns the
// input ready and the result valid.
// ----------------------------------------------------------------------------
module lsob_ctrl
    import lsob_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output lsob_cmd_t      cmd
);

    lsob_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.sq_en  = 1'b1;
                state_next = ST_WT;
            end
            ST_WT: begin
                cmd.wt_en  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_OFF;
            end
            ST_OFF: begin
                cmd.off_en = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the result register frees up
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = cmd.out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/lsob_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsob_dp
// Datapath: per-leg offset state, smoothstep weight, blend and saturating
// sum, plus the result register.
// ----------------------------------------------------------------------------
module lsob_dp
    import lsob_pkg::*;
#(
    parameter int LEGS = LEGS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire lsob_cmd_t                 cmd,
    input  wire logic [LEG_W-1:0]          s_leg,
    input  wire logic signed [POS_W-1:0]   s_planned_x,
    input  wire logic signed [POS_W-1:0]   s_planned_y,
    input  wire logic signed [POS_W-1:0]   s_planned_z,
    input  wire logic                      s_swing,
    input  wire logic signed [PHASE_W-1:0] s_swing_phase,
    input  wire logic signed [POS_W-1:0]   s_live_x,
    input  wire logic signed [POS_W-1:0]   s_live_z,
    input  wire logic                      s_live_valid,
    output logic signed [POS_W-1:0]        m_out_x,
    output logic signed [POS_W-1:0]        m_out_y,
    output logic signed [POS_W-1:0]        m_out_z
);

    localparam int IDX_W = (LEGS > 1) ? $clog2(LEGS) : 1;
    localparam int EXT_W = 4;
    localparam logic [EXT_W-1:0] LEGS_CNT = EXT_W'(LEGS);

    // per-leg state
    logic [LEGS-1:0]         flag_reg;
    logic signed [POS_W-1:0] liftoff_x_reg [LEGS];
    logic signed [POS_W-1:0] liftoff_z_reg [LEGS];
    logic signed [POS_W-1:0] landed_x_reg  [LEGS];
    logic signed [POS_W-1:0] landed_z_reg  [LEGS];
    logic signed [POS_W-1:0] current_x_reg [LEGS];
    logic signed [POS_W-1:0] current_z_reg [LEGS];

    // transaction registers
    logic [IDX_W-1:0]         idx_reg;
    logic                     active_reg, swing_reg;
    logic signed [POS_W-1:0]  px_reg, py_reg, pz_reg;
    logic signed [POS_W-1:0]  from_x_reg, from_z_reg;
    logic signed [DIFF_W-1:0] d_x_reg, d_z_reg;
    logic [T_W-1:0]           t_reg, t2_reg, b_reg;
    logic [K_W-1:0]           k_reg;
    logic signed [PROD_W-1:0] prod_x_reg, prod_z_reg;
    logic signed [POS_W-1:0]  off_x_reg, off_z_reg;
    logic signed [POS_W-1:0]  out_x_reg, out_y_reg, out_z_reg;

    // load-time signals
    logic [EXT_W-1:0]         leg_ext;
    logic                     in_range, active_in, flag_cur;
    logic [IDX_W-1:0]         idx;
    logic signed [POS_W-1:0]  from_x_in, from_z_in;
    logic [T_W-1:0]           t_in;

    // arithmetic
    logic [2*T_W-1:0]         sq;
    logic [T_W+K_W-1:0]       wt;
    logic signed [T_W:0]      b_s;
    logic signed [DIFF_W-1:0] blend_x, blend_z;
    logic signed [DIFF_W-1:0] off_x_w, off_z_w;
    logic signed [POS_W-1:0]  sel_x, sel_z;
    logic signed [POS_W:0]    sum_x, sum_z;

    assign leg_ext   = {{(EXT_W-LEG_W){1'b0}}, s_leg};
    assign in_range  = leg_ext < LEGS_CNT;
    assign idx       = in_range ? leg_ext[IDX_W-1:0] : '0;
    assign active_in = s_live_valid && in_range;
    assign flag_cur  = flag_reg[idx];

    // swing uses liftoff (landed on entry), stance uses landed (current on entry)
    always_comb begin
        if (s_swing) begin
            from_x_in = flag_cur ? liftoff_x_reg[idx] : landed_x_reg[idx];
            from_z_in = flag_cur ? liftoff_z_reg[idx] : landed_z_reg[idx];
        end else begin
            from_x_in = flag_cur ? current_x_reg[idx] : landed_x_reg[idx];
            from_z_in = flag_cur ? current_z_reg[idx] : landed_z_reg[idx];
        end
    end

    // clamp phase to 0..1
    always_comb begin
        if (s_swing_phase[PHASE_W-1]) begin
            t_in = '0;
        end else if (s_swing_phase > $signed({1'b0, Q16_ONE})) begin
            t_in = Q16_ONE;
        end else begin
            t_in = s_swing_phase[T_W-1:0];
        end
    end

    assign sq  = t_reg * t_reg;
    assign wt  = t2_reg * k_reg;
    assign b_s = $signed({1'b0, b_reg});

    assign blend_x = prod_x_reg[DIFF_W+15:16];
    assign blend_z = prod_z_reg[DIFF_W+15:16];
    assign off_x_w = DIFF_W'(from_x_reg) + blend_x;
    assign off_z_w = DIFF_W'(from_z_reg) + blend_z;

    assign sel_x = swing_reg ? off_x_reg : from_x_reg;
    assign sel_z = swing_reg ? off_z_reg : from_z_reg;
    assign sum_x = (POS_W+1)'(px_reg) + (POS_W+1)'(sel_x);
    assign sum_z = (POS_W+1)'(pz_reg) + (POS_W+1)'(sel_z);

    // per-leg state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= '0;
            for (int i = 0; i < LEGS; i++) begin
                liftoff_x_reg[i] <= '0;
                liftoff_z_reg[i] <= '0;
                landed_x_reg[i]  <= '0;
                landed_z_reg[i]  <= '0;
                current_x_reg[i] <= '0;
                current_z_reg[i] <= '0;
            end
        end else begin
            if (cmd.load && active_in) begin
                flag_reg[idx] <= s_swing;
                if (s_swing && !flag_cur) begin
                    liftoff_x_reg[idx] <= landed_x_reg[idx];
                    liftoff_z_reg[idx] <= landed_z_reg[idx];
                end
                if (!s_swing && flag_cur) begin
                    landed_x_reg[idx] <= current_x_reg[idx];
                    landed_z_reg[idx] <= current_z_reg[idx];
                end
            end
            if (cmd.off_en && active_reg && swing_reg) begin
                current_x_reg[idx_reg] <= off_x_w[POS_W-1:0];
                current_z_reg[idx_reg] <= off_z_w[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (cmd.load) begin
            active_reg <= active_in;
        end
    end

    // payload pipeline
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            idx_reg    <= idx;
            swing_reg  <= s_swing;
            px_reg     <= s_planned_x;
            py_reg     <= s_planned_y;
            pz_reg     <= s_planned_z;
            from_x_reg <= from_x_in;
            from_z_reg <= from_z_in;
            d_x_reg    <= DIFF_W'(s_live_x) - DIFF_W'(from_x_in);
            d_z_reg    <= DIFF_W'(s_live_z) - DIFF_W'(from_z_in);
            t_reg      <= t_in;
        end
        if (cmd.sq_en) begin
            t2_reg <= sq[T_W+15:16];
            k_reg  <= Q16_THREE - {t_reg, 1'b0};
        end
        if (cmd.wt_en) begin
            b_reg <= wt[T_W+15:16];
        end
        if (cmd.mul_en) begin
            prod_x_reg <= PROD_W'(d_x_reg * b_s);
            prod_z_reg <= PROD_W'(d_z_reg * b_s);
        end
        if (cmd.off_en) begin
            off_x_reg <= off_x_w[POS_W-1:0];
            off_z_reg <= off_z_w[POS_W-1:0];
        end
        if (cmd.out_load) begin
            out_x_reg <= active_reg ? sat_pos(sum_x) : px_reg;
            out_y_reg <= py_reg;
            out_z_reg <= active_reg ? sat_pos(sum_z) : pz_reg;
        end
    end

    assign m_out_x = out_x_reg;
    assign m_out_y = out_y_reg;
    assign m_out_z = out_z_reg;

endmodule
`default_nettype wire

// File: rtl/leg_swing_offset_blender.sv
`default_nettype none
// ----------------------------------------------------------------------------
// leg_swing_offset_blender
// Adds a per-leg foot-placement offset to a planned foot position, blending
// the offset through the swing phase with a smoothstep weight.
// ----------------------------------------------------------------------------
// Each input transaction is one control tick for one leg. The block keeps,
// per leg, a swing flag and liftoff, landed and current offsets, all zero
// after reset. Entering swing copies landed into liftoff; during swing the
// offset moves from liftoff toward the live target with weight t*t*(3-2t),
// t being the Q16 phase clamped to 0..1; entering stance copies current into
// landed, and stance applies landed. X and z get planned + offset, saturated
// to 24 bits; y passes through. With live_valid low, or a leg index at or
// above LEGS, the planned position goes out unchanged and no state moves.
// Each transaction runs the five-step sequence (clamp/capture, square,
// weight, blend multiply, offset add) plus the result load, sharing one set
// of datapath registers; no new transaction is taken before that load.
// The result sits in an output register, so the next transaction is taken
// while it waits; a stalled output holds the sequencer in its last step.
// ----------------------------------------------------------------------------
module leg_swing_offset_blender
    import lsob_pkg::*;
#(
    parameter int LEGS = LEGS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // input transaction
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [LEG_W-1:0]          s_leg,
    input  wire logic signed [POS_W-1:0]   s_planned_x,
    input  wire logic signed [POS_W-1:0]   s_planned_y,
    input  wire logic signed [POS_W-1:0]   s_planned_z,
    input  wire logic                      s_swing,
    input  wire logic signed [PHASE_W-1:0] s_swing_phase,
    input  wire logic signed [POS_W-1:0]   s_live_x,
    input  wire logic signed [POS_W-1:0]   s_live_z,
    input  wire logic                      s_live_valid,
    // result transaction
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [POS_W-1:0]        m_out_x,
    output logic signed [POS_W-1:0]        m_out_y,
    output logic signed [POS_W-1:0]        m_out_z
);

    lsob_cmd_t cmd;

    // sequencer: steps the datapath and owns both handshakes
    lsob_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // datapath: per-leg state, weight, blend, saturating sum, result register
    lsob_dp #(
        .LEGS (LEGS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_leg         (s_leg),
        .s_planned_x   (s_planned_x),
        .s_planned_y   (s_planned_y),
        .s_planned_z   (s_planned_z),
        .s_swing       (s_swing),
        .s_swing_phase (s_swing_phase),
        .s_live_x      (s_live_x),
        .s_live_z      (s_live_z),
        .s_live_valid  (s_live_valid),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_out_z       (m_out_z)
    );

endmodule
`default_nettype wire
